/* design/pso_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_pkg
// Shared constants, register indexes and saturation helpers for the particle
// swarm coordinate update pipeline.
// ----------------------------------------------------------------------------
package pso_pkg;

    // Index limits; coordinates beyond them pass through unchanged
    localparam int unsigned MAX_PARTICLES  = 65536;
    localparam int unsigned MAX_DIMENSIONS = 256;

    // Field widths
    localparam int PIDX_W = 16;
    localparam int DIDX_W = 8;
    localparam int Q_W    = 32;
    localparam int SEED_W = 31;
    localparam int FRAC_W = 24;
    localparam int ADDR_W = 3;

    // Pipeline depth: stage 1 takes the input item, the last stage is the
    // output register
    localparam int PIPE_DEPTH = 9;

    // Register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_INERTIA  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COG_GAIN = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SOC_GAIN = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LOWER    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_UPPER    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ITER     = 3'd5;

    // Register reset values
    localparam logic signed [Q_W-1:0] RST_INERTIA  = 32'sd47186;
    localparam logic signed [Q_W-1:0] RST_COG_GAIN = 32'sd97648;
    localparam logic signed [Q_W-1:0] RST_SOC_GAIN = 32'sd97648;
    localparam logic signed [Q_W-1:0] RST_LOWER    = -32'sd335544;
    localparam logic signed [Q_W-1:0] RST_UPPER    = 32'sd335544;
    localparam logic [SEED_W-1:0]     RST_ITER     = 31'd1;

    // Seed and hash constants
    localparam logic [31:0] HASH_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B    = 32'h846ca68b;
    localparam logic [31:0] SEED_XOR      = 32'hA5A5A5A5;
    localparam logic [31:0] SEED_MUL_ITER = 32'd73856093;
    localparam logic [31:0] SEED_MUL_PART = 32'd19349663;
    localparam logic [31:0] SEED_MUL_DIM  = 32'd83492791;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // Clip a signed 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        priority if (v > SAT_MAX) begin
            res = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Sign-extend a Q16.16 value to 64 bits
    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

/* design/pso_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_mix
// Two-stage integer hash of a 32-bit seed; yields a Q0.24 random fraction.
// ----------------------------------------------------------------------------
module pso_mix
    import pso_pkg::*;
(
    input  logic              i_clk,
    input  logic [1:0]        i_en,     // load enables of the two hash stages
    input  logic [31:0]       i_seed,
    output logic [FRAC_W-1:0] o_frac
);

    logic [31:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] w_s0;
    logic [31:0] w_s1;
    logic [31:0] w_s2;

    assign w_s0 = i_seed ^ (i_seed >> 16);
    assign w_s1 = r_m1 ^ (r_m1 >> 15);
    assign w_s2 = r_m2 ^ (r_m2 >> 16);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m1 <= w_s0 * HASH_MUL_A;
        end
        if (i_en[1]) begin
            r_m2 <= w_s1 * HASH_MUL_B;
        end
    end

    assign o_frac = w_s2[FRAC_W-1:0];

endmodule

/* design/pso_attract.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_attract
// Attraction term gain * frac * diff in three stages, each product floored
// and saturated back to Q16.16.
// ----------------------------------------------------------------------------
module pso_attract
    import pso_pkg::*;
(
    input  logic                  i_clk,
    input  logic [2:0]            i_en,    // load enables of the three stages
    input  logic signed [Q_W-1:0] i_gain,  // Q16.16
    input  logic [FRAC_W-1:0]     i_frac,  // Q0.24, valid with enable bit 0
    input  logic signed [Q_W-1:0] i_diff,  // Q16.16, valid with enable bit 2
    output logic signed [Q_W-1:0] o_term
);

    logic signed [56:0]    r_p;
    logic signed [Q_W-1:0] r_a;
    logic signed [63:0]    r_q;
    logic signed [63:0]    w_p_ext;
    logic signed [Q_W-1:0] w_a;

    assign w_p_ext = {{7{r_p[56]}}, r_p};
    assign w_a     = sat32(w_p_ext >>> 24);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p <= i_gain * $signed({1'b0, i_frac});
        end
        if (i_en[1]) begin
            r_a <= w_a;
        end
        if (i_en[2]) begin
            r_q <= r_a * i_diff;
        end
    end

    assign o_term = sat32(r_q >>> 16);

endmodule

/* design/pso_particle_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_particle_update
// Particle swarm velocity and position update, one coordinate per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one coordinate item (indexes, x, v, pbest, gbest).
//   Output stream m_axis_*: new position and velocity in tdata, clamp flag
//   in tuser. One result item per input item, in order.
//   Config channel i_cfg_*: register index and data; always ready. Write
//   only while the pipeline is empty.
// Throughput: one item per cycle while the output is ready; the nine-stage
//   pipeline is fully pipelined, with the hash multipliers and the two
//   attraction-term multipliers each in stages of their own.
// Path: an accepted item shows valid once it reaches the output register.
// Stall: each stage holds while its successor is full and stalled; empty
//   stages still fill, so bubbles collapse and the input keeps flowing
//   until all nine stages hold items. Nothing is dropped or repeated.
// Reset: synchronous, active low; empties the pipeline and loads the
//   register defaults (w=0.72, c1=c2=1.49, bounds +-5.12, seed 1).
// ----------------------------------------------------------------------------
module pso_particle_update
    import pso_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] particle_index, [23:16] dim_index, [55:24] position,
    // [87:56] velocity, [119:88] personal_best, [151:120] global_best
    input  logic [151:0]      s_axis_tdata,
    // result item stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [31:0] new_position, [63:32] new_velocity
    output logic [63:0]       m_axis_tdata,
    // [0] was_clamped
    output logic [0:0]        m_axis_tuser,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] r_w;
    logic signed [Q_W-1:0] r_c1;
    logic signed [Q_W-1:0] r_c2;
    logic signed [Q_W-1:0] r_lo;
    logic signed [Q_W-1:0] r_hi;
    logic [SEED_W-1:0]     r_iter;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= RST_INERTIA;
            r_c1   <= RST_COG_GAIN;
            r_c2   <= RST_SOC_GAIN;
            r_lo   <= RST_LOWER;
            r_hi   <= RST_UPPER;
            r_iter <= RST_ITER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_INERTIA:  r_w    <= i_cfg_data;
                REG_COG_GAIN: r_c1   <= i_cfg_data;
                REG_SOC_GAIN: r_c2   <= i_cfg_data;
                REG_LOWER:    r_lo   <= i_cfg_data;
                REG_UPPER:    r_hi   <= i_cfg_data;
                REG_ITER:     r_iter <= i_cfg_data[SEED_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // moves on; valid bits travel with the data
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH:1] r_vld;
    logic [PIPE_DEPTH:1] w_ready;

    always_comb begin
        w_ready[PIPE_DEPTH] = !r_vld[PIPE_DEPTH] || m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
    end

    assign s_axis_tready = w_ready[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [PIDX_W-1:0]     w_pidx;
    logic [DIDX_W-1:0]     w_didx;
    logic signed [Q_W-1:0] w_x;
    logic signed [Q_W-1:0] w_v;
    logic signed [Q_W-1:0] w_pb;
    logic signed [Q_W-1:0] w_gb;
    logic                  w_byp;

    assign w_pidx = s_axis_tdata[15:0];
    assign w_didx = s_axis_tdata[23:16];
    assign w_x    = s_axis_tdata[55:24];
    assign w_v    = s_axis_tdata[87:56];
    assign w_pb   = s_axis_tdata[119:88];
    assign w_gb   = s_axis_tdata[151:120];

    // index out of range: pass x and v through untouched
    assign w_byp = ({16'd0, w_pidx} >= 32'(MAX_PARTICLES)) ||
                   ({24'd0, w_didx} >= 32'(MAX_DIMENSIONS));

    // ------------------------------------------------------------------
    // Carried fields (one tap per stage)
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] r_x   [1:PIPE_DEPTH-1];
    logic signed [Q_W-1:0] r_v   [1:PIPE_DEPTH-1];
    logic                  r_byp [1:PIPE_DEPTH-1];
    logic signed [Q_W-1:0] r_d1  [1:6];
    logic signed [Q_W-1:0] r_d2  [1:6];
    logic signed [Q_W-1:0] r_wt  [2:7];

    // stage 1: seed partial products, differences, inertia product
    logic [31:0]        r1_iter;
    logic [31:0]        r1_part;
    logic [31:0]        r1_dim;
    logic signed [63:0] r1_wv;

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            r1_iter  <= {1'b0, r_iter} * SEED_MUL_ITER;
            r1_part  <= {16'd0, w_pidx} * SEED_MUL_PART;
            r1_dim   <= {24'd0, w_didx} * SEED_MUL_DIM;
            r1_wv    <= r_w * w_v;
            r_d1[1]  <= sat32(sx64(w_pb) - sx64(w_x));
            r_d2[1]  <= sat32(sx64(w_gb) - sx64(w_x));
            r_x[1]   <= w_x;
            r_v[1]   <= w_v;
            r_byp[1] <= w_byp;
        end
        for (int k = 2; k <= PIPE_DEPTH - 1; k++) begin
            if (w_ready[k]) begin
                r_x[k]   <= r_x[k-1];
                r_v[k]   <= r_v[k-1];
                r_byp[k] <= r_byp[k-1];
            end
        end
        for (int k = 2; k <= 6; k++) begin
            if (w_ready[k]) begin
                r_d1[k] <= r_d1[k-1];
                r_d2[k] <= r_d2[k-1];
            end
        end
        for (int k = 3; k <= 7; k++) begin
            if (w_ready[k]) begin
                r_wt[k] <= r_wt[k-1];
            end
        end
    end

    // stage 2: seed sum, floored inertia term
    logic [31:0] r2_seed;

    always_ff @(posedge i_clk) begin
        if (w_ready[2]) begin
            r2_seed <= r1_iter + r1_part + r1_dim;
            r_wt[2] <= sat32(r1_wv >>> 16);
        end
    end

    // stages 3-4: hash lanes for r1 and r2
    logic [FRAC_W-1:0] w_r1;
    logic [FRAC_W-1:0] w_r2;

    pso_mix u_mix1 (
        .i_clk  (i_clk),
        .i_en   (w_ready[4:3]),
        .i_seed (r2_seed),
        .o_frac (w_r1)
    );

    pso_mix u_mix2 (
        .i_clk  (i_clk),
        .i_en   (w_ready[4:3]),
        .i_seed (r2_seed ^ SEED_XOR),
        .o_frac (w_r2)
    );

    // stages 5-7: attraction terms
    logic signed [Q_W-1:0] w_t1;
    logic signed [Q_W-1:0] w_t2;

    pso_attract u_att_cog (
        .i_clk  (i_clk),
        .i_en   (w_ready[7:5]),
        .i_gain (r_c1),
        .i_frac (w_r1),
        .i_diff (r_d1[6]),
        .o_term (w_t1)
    );

    pso_attract u_att_soc (
        .i_clk  (i_clk),
        .i_en   (w_ready[7:5]),
        .i_gain (r_c2),
        .i_frac (w_r2),
        .i_diff (r_d2[6]),
        .o_term (w_t2)
    );

    // stage 8: velocity sum, saturated once
    logic signed [Q_W-1:0] r8_vn;

    always_ff @(posedge i_clk) begin
        if (w_ready[8]) begin
            r8_vn <= sat32(sx64(r_wt[7]) + sx64(w_t1) + sx64(w_t2));
        end
    end

    // stage 9: new position, bound clamp, output register
    logic signed [Q_W-1:0] w_xs;
    logic signed [Q_W-1:0] n_pos;
    logic signed [Q_W-1:0] n_vel;
    logic                  n_clamp;
    logic signed [Q_W-1:0] r_pos;
    logic signed [Q_W-1:0] r_vel;
    logic                  r_clamp;

    assign w_xs = sat32(sx64(r_x[8]) + sx64(r8_vn));

    always_comb begin
        priority if (r_byp[8]) begin
            n_pos   = r_x[8];
            n_vel   = r_v[8];
            n_clamp = 1'b0;
        end else if (w_xs < r_lo) begin
            // lower bound is tested first, also for inverted bounds
            n_pos   = r_lo;
            n_vel   = '0;
            n_clamp = 1'b1;
        end else if (w_xs > r_hi) begin
            n_pos   = r_hi;
            n_vel   = '0;
            n_clamp = 1'b1;
        end else begin
            n_pos   = w_xs;
            n_vel   = r8_vn;
            n_clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[PIPE_DEPTH]) begin
            r_pos   <= n_pos;
            r_vel   <= n_vel;
            r_clamp <= n_clamp;
        end
    end

    assign m_axis_tvalid   = r_vld[PIPE_DEPTH];
    assign m_axis_tdata    = {r_vel, r_pos};
    assign m_axis_tuser[0] = r_clamp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clamp_zero_vel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == 32'd0))
        else $error("clamped result carries nonzero velocity");

    a_clamp_on_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((m_axis_tdata[31:0] == r_lo) || (m_axis_tdata[31:0] == r_hi)))
        else $error("clamped position is not a bound");

    a_no_item_loss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && m_axis_tready) |=>
        ($countones(r_vld) >= $past($countones(r_vld))))
        else $error("item lost inside pipeline");

    a_no_item_dup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) |=>
        ($countones(r_vld) <= $past($countones(r_vld))))
        else $error("item created inside pipeline");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the particle swarm coordinate update pipeline.
// A queue of coordinate items feeds a bursty stream driver. Each accepted
// item is run through a bit-accurate predictor: seed hash, Q16.16 velocity
// and position update with saturation, and bound clamping. The monitor pulls
// results against a randomly stalling sink and compares them in order. The
// registers are reprogrammed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
    import pso_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    localparam logic signed [31:0] Q_POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_NEG_MAX = 32'sh8000_0000;
    localparam logic signed [63:0] CLIP_HI   = 64'sd2147483647;
    localparam logic signed [63:0] CLIP_LO   = -64'sd2147483648;

    // One coordinate item; the last member lands in the lowest bits of tdata
    typedef struct packed {
        logic signed [31:0] global_best;
        logic signed [31:0] personal_best;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic [7:0]         dim_index;
        logic [15:0]        particle_index;
    } t_coord_item;

    typedef struct packed {
        logic               was_clamped;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_position;
    } t_coord_update;

    // Sink ready patterns
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_pattern;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [151:0]       s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;
    logic [0:0]         m_axis_tuser;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [ADDR_W-1:0]  i_cfg_index   = '0;
    logic [31:0]        i_cfg_data    = '0;

    // Predictor's copy of the register file
    logic signed [31:0] cfg_w    = RST_INERTIA;
    logic signed [31:0] cfg_c1   = RST_COG_GAIN;
    logic signed [31:0] cfg_c2   = RST_SOC_GAIN;
    logic signed [31:0] cfg_lo   = RST_LOWER;
    logic signed [31:0] cfg_hi   = RST_UPPER;
    logic [SEED_W-1:0]  cfg_seed = RST_ITER;

    t_coord_item   pending_coords[$];
    t_coord_update expected_updates[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int cycle_count = 0;

    pso_particle_update u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clip a wide signed value into Q16.16 range
    function automatic logic signed [31:0] clip_q(input logic signed [63:0] v);
        if (v > CLIP_HI) return Q_POS_MAX;
        if (v < CLIP_LO) return Q_NEG_MAX;
        return v[31:0];
    endfunction

    // Integer avalanche hash behind the random fractions
    function automatic logic [31:0] mix32(input logic [31:0] s);
        logic [31:0] h;
        h = s;
        h ^= h >> 16;
        h *= HASH_MUL_A;
        h ^= h >> 15;
        h *= HASH_MUL_B;
        h ^= h >> 16;
        return h;
    endfunction

    // gain (Q16.16) * frac (Q0.24) * diff (Q16.16); floor and clip after
    // each product
    function automatic logic signed [31:0] attract_term(input logic signed [31:0] gain,
                                                        input logic [23:0] frac,
                                                        input logic signed [31:0] diff);
        logic signed [63:0] g64, f64, d64, a64;
        g64 = gain;
        f64 = {40'd0, frac};
        d64 = diff;
        a64 = clip_q((g64 * f64) >>> 24);
        return clip_q((a64 * d64) >>> 16);
    endfunction

    function automatic t_coord_update predict_coord(input t_coord_item c);
        logic [31:0]        seed;
        logic [23:0]        r1, r2;
        logic signed [31:0] x, v, p, g, vn, xn;
        logic signed [63:0] x64, v64, p64, g64, w64, t_in, t_cog, t_soc, vn64;
        t_coord_update      u;
        seed = {1'b0, cfg_seed} * SEED_MUL_ITER
             + {16'd0, c.particle_index} * SEED_MUL_PART
             + {24'd0, c.dim_index} * SEED_MUL_DIM;
        r1 = 24'(mix32(seed));
        r2 = 24'(mix32(seed ^ SEED_XOR));
        x = c.position;
        v = c.velocity;
        p = c.personal_best;
        g = c.global_best;
        x64 = x;
        v64 = v;
        p64 = p;
        g64 = g;
        w64 = cfg_w;
        t_in  = clip_q((w64 * v64) >>> 16);
        t_cog = attract_term(cfg_c1, r1, clip_q(p64 - x64));
        t_soc = attract_term(cfg_c2, r2, clip_q(g64 - x64));
        vn = clip_q(t_in + t_cog + t_soc);
        vn64 = vn;
        xn = clip_q(x64 + vn64);
        u.was_clamped = 1'b0;
        // Lower bound is tested first, so it wins on inverted bounds
        if (xn < cfg_lo) begin
            xn = cfg_lo;
            vn = '0;
            u.was_clamped = 1'b1;
        end else if (xn > cfg_hi) begin
            xn = cfg_hi;
            vn = '0;
            u.was_clamped = 1'b1;
        end
        u.new_position = xn;
        u.new_velocity = vn;
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Q16.16 value: often near the default bounds, plus zero, extremes and full range
    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return Q_POS_MAX;
            3:       return Q_NEG_MAX;
            4:       return '0;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    function automatic t_coord_item random_coord();
        t_coord_item c;
        c.particle_index = 16'($urandom);
        c.dim_index      = 8'($urandom);
        c.position       = pick_q();
        c.velocity       = pick_q();
        c.personal_best  = pick_q();
        c.global_best    = pick_q();
        return c;
    endfunction

    task automatic queue_coord(input logic [15:0] pidx, input logic [7:0] didx,
                               input logic [31:0] x, input logic [31:0] v,
                               input logic [31:0] p, input logic [31:0] g);
        t_coord_item c;
        c.particle_index = pidx;
        c.dim_index      = didx;
        c.position       = x;
        c.velocity       = v;
        c.personal_best  = p;
        c.global_best    = g;
        pending_coords = {pending_coords, c};
        n_queued++;
    endtask

    task automatic queue_random(input int count);
        t_coord_item c;
        for (int k = 0; k < count; k++) begin
            c = random_coord();
            queue_coord(c.particle_index, c.dim_index, c.position, c.velocity,
                        c.personal_best, c.global_best);
        end
    endtask

    // Hold until every queued item went in and every result came out, then
    // let the pipeline settle
    task automatic wait_idle();
        while (n_accepted != n_queued || expected_updates.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Write all register indexes in order, including the two unused ones,
    // keeping valid high across the run of writes
    task automatic program_regs(input logic [31:0] w, input logic [31:0] c1,
                                input logic [31:0] c2, input logic [31:0] lo,
                                input logic [31:0] hi, input logic [31:0] seed_data);
        logic [31:0] vals [8];
        vals = '{w, c1, c2, lo, hi, seed_data, $urandom, $urandom};
        for (int r = 0; r < 8; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= ADDR_W'(r);
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (ADDR_W'(r))
                REG_INERTIA:  cfg_w    = vals[r];
                REG_COG_GAIN: cfg_c1   = vals[r];
                REG_SOC_GAIN: cfg_c2   = vals[r];
                REG_LOWER:    cfg_lo   = vals[r];
                REG_UPPER:    cfg_hi   = vals[r];
                REG_ITER:     cfg_seed = vals[r][SEED_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of random length with random gaps between them.
    // The expectation is formed the moment the block takes an item.
    // ------------------------------------------------------------------
    t_coord_item held_coord = '0;
    logic        offering;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_updates = {expected_updates, predict_coord(held_coord)};
                n_accepted++;
                offering = 1'b0;
            end
            // Load the next item unless we are sitting in a gap
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_coords.size() > 0) begin
                    held_coord = pending_coords.pop_front();
                    offering   = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Start a new burst; a quarter of them follow with no gap
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_axis_tvalid <= offering;
            s_axis_tdata  <= held_coord;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: ready follows a random pattern that is redrawn whenever
    // its stretch runs out. Twice in the run, hold off for a long stretch while items
    // are still pending, so the pipeline fills and backs up the input.
    // ------------------------------------------------------------------
    t_rx_pattern rx_pattern     = RX_FREE;
    int          rx_left        = 0;
    int          hold_off_left  = 0;
    int          hold_offs_done = 0;
    logic        rx_ready       = 1'b0;

    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            rx_ready = 1'b0;
        end else if (hold_offs_done < 2 && n_accepted >= 250 + 450 * hold_offs_done
                     && pending_coords.size() > 40) begin
            hold_off_left = HOLD_CYCLES;
            hold_offs_done++;
            rx_ready = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_left    = $urandom_range(16, 120);
            end
            rx_left--;
            case (rx_pattern)
                RX_FREE:   rx_ready = 1'b1;
                RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
                default:   rx_ready = ~rx_ready;
            endcase
        end
        m_axis_tready <= rx_ready;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest expectation
    // ------------------------------------------------------------------
    t_coord_update want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_updates.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_PRINTS)
                    $display("%0t: result with nothing expected, got pos %0d vel %0d clamp %0d",
                             $time, $signed(m_axis_tdata[31:0]),
                             $signed(m_axis_tdata[63:32]), m_axis_tuser[0]);
            end else begin
                want = expected_updates.pop_front();
                if (m_axis_tdata[31:0] !== want.new_position) begin
                    n_errors++;
                    if (n_errors <= MAX_PRINTS)
                        $display("%0t: new_position expected %0d, got %0d", $time,
                                 want.new_position, $signed(m_axis_tdata[31:0]));
                end
                if (m_axis_tdata[63:32] !== want.new_velocity) begin
                    n_errors++;
                    if (n_errors <= MAX_PRINTS)
                        $display("%0t: new_velocity expected %0d, got %0d", $time,
                                 want.new_velocity, $signed(m_axis_tdata[63:32]));
                end
                if (m_axis_tuser[0] !== want.was_clamped) begin
                    n_errors++;
                    if (n_errors <= MAX_PRINTS)
                        $display("%0t: was_clamped expected %0d, got %0d", $time,
                                 want.was_clamped, m_axis_tuser[0]);
                end
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: w=0.72, c1=c2=1.49, bounds +-5.12
        queue_coord(16'h0000, 8'h00, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_coord(16'hFFFF, 8'hFF, 32'sd65536, 32'sd32768, 32'sd131072, -32'sd65536);
        queue_coord(16'h1234, 8'h56, 32'sd100000, -32'sd50000, 32'sd0, 32'sd200000);
        // Falls below the lower bound
        queue_coord(16'h0001, 8'h01, -32'sd300000, -32'sd250000, -32'sd300000, -32'sd300000);
        // Overshoots the upper bound
        queue_coord(16'h0002, 8'h02, 32'sd300000, 32'sd250000, 32'sd300000, 32'sd300000);
        // Saturated differences and sums
        queue_coord(16'h0003, 8'h80, Q_POS_MAX, Q_POS_MAX, Q_NEG_MAX, Q_NEG_MAX);
        queue_coord(16'h8000, 8'h7F, Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX, Q_POS_MAX);
        queue_coord(16'h7FFF, 8'h01, Q_POS_MAX, 32'sd0, Q_POS_MAX, Q_POS_MAX);
        queue_coord(16'h0004, 8'h04, 32'sd0, Q_NEG_MAX, 32'sd0, 32'sd0);
        queue_coord(16'h0005, 8'h05, 32'sd0, 32'sd0, Q_POS_MAX, Q_NEG_MAX);
        // Sitting exactly on each bound stays unclamped
        queue_coord(16'h0006, 8'h06, RST_UPPER, 32'sd0, RST_UPPER, RST_UPPER);
        queue_coord(16'h0007, 8'h07, RST_LOWER, 32'sd0, RST_LOWER, RST_LOWER);
        queue_random(100);
        wait_idle();

        // Extreme gains, widest bounds, seed register with bit 31 set (masked)
        program_regs(Q_POS_MAX, Q_POS_MAX, Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX, 32'hFFFF_FFFF);
        queue_coord(16'hFFFF, 8'hFF, Q_POS_MAX, Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX);
        queue_coord(16'h0000, 8'h00, Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX);
        queue_coord(16'hA5A5, 8'h5A, 32'sd65536, -32'sd65536, 32'sd0, 32'sd131072);
        queue_random(60);
        wait_idle();

        // Inverted bounds with zero gains: position passes straight to the clamp
        program_regs(32'sd0, 32'sd0, 32'sd0, 32'sd100000, -32'sd100000, 32'd0);
        queue_coord(16'h0010, 8'h10, 32'sd200000, 32'sd50000, 32'sd0, 32'sd0);
        queue_coord(16'h0011, 8'h11, 32'sd0, -32'sd50000, 32'sd0, 32'sd0);
        queue_coord(16'h0012, 8'h12, 32'sd100000, 32'sd0, 32'sd0, 32'sd0);
        queue_coord(16'h0013, 8'h13, -32'sd200000, 32'sd0, 32'sd0, 32'sd0);
        queue_coord(16'h0014, 8'h14, -32'sd100000, 32'sd0, 32'sd0, 32'sd0);
        queue_random(60);
        wait_idle();

        // Most negative inertia and cognitive gain, largest seed
        program_regs(Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX, RST_LOWER, RST_UPPER, 32'h7FFF_FFFF);
        queue_random(60);
        wait_idle();

        // Random settings, mostly moderate, sometimes full range
        for (int ph = 0; ph < 7; ph++) begin
            logic [31:0] w, c1, c2, lo, hi;
            w  = ($urandom_range(0, 7) == 0) ? $urandom
                 : 32'($urandom_range(0, 3 << 16)) - 32'(3 << 15);
            c1 = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 4 << 16));
            c2 = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 4 << 16));
            if ($urandom_range(0, 7) == 0) begin
                lo = $urandom;
                hi = $urandom;
            end else begin
                lo = -32'($urandom_range(0, 1 << 20));
                hi = 32'($urandom_range(0, 1 << 20));
            end
            program_regs(w, c1, c2, lo, hi, $urandom);
            queue_random(125);
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
